/* hdl/wta_pkg.sv */
`timescale 1ns / 1ps

package wta_pkg;

  localparam int WINDOW_DEF   = 8;
  localparam int SAMPLE_W     = 8;
  localparam int CORDIC_STEPS = 22;
  localparam int STEP_W       = 5;
  localparam int PRESHIFT     = 16;
  localparam int GUARD_W      = 3;
  localparam int Z_W          = 26;
  localparam int ROUND_BITS   = 12;
  localparam int ZR_W         = Z_W - ROUND_BITS;
  localparam int ANG_W        = 13;
  localparam int MAG_W        = 11;

  localparam logic [ANG_W-1:0] HALF_TURN  = 13'd2880;
  localparam logic [MAG_W-1:0] QUARTER    = 11'd1440;
  localparam logic [Z_W-1:0]   ROUND_HALF = 26'd2048;

  // datapath operations, one per microcode step
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_PRIME,
    OP_SUM,
    OP_CLASSIFY,
    OP_ITER,
    OP_FINISH,
    OP_EMIT
  } op_t;

  // branch conditions
  typedef enum logic [2:0] {
    BR_NEXT,
    BR_GOTO,
    BR_IDLE,
    BR_SUM_MORE,
    BR_ITER_MORE,
    BR_SPECIAL
  } br_t;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_WAIT     = 3'd0;
  localparam pc_t PC_PRIME    = 3'd1;
  localparam pc_t PC_SUM      = 3'd2;
  localparam pc_t PC_CLASSIFY = 3'd3;
  localparam pc_t PC_ITER     = 3'd4;
  localparam pc_t PC_FINISH   = 3'd5;
  localparam pc_t PC_EMIT     = 3'd6;

  typedef struct packed {
    op_t op;
    br_t br;
    pc_t target;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic sum_more;
    logic iter_more;
    logic special;
    logic hold;
  } stat_t;

  // microcode ROM
  function automatic ctl_t ucode(input pc_t pc);
    ctl_t c;
    unique case (pc)
      PC_WAIT:     c = '{op: OP_WAIT,     br: BR_IDLE,      target: PC_WAIT};
      PC_PRIME:    c = '{op: OP_PRIME,    br: BR_NEXT,      target: PC_WAIT};
      PC_SUM:      c = '{op: OP_SUM,      br: BR_SUM_MORE,  target: PC_SUM};
      PC_CLASSIFY: c = '{op: OP_CLASSIFY, br: BR_SPECIAL,   target: PC_EMIT};
      PC_ITER:     c = '{op: OP_ITER,     br: BR_ITER_MORE, target: PC_ITER};
      PC_FINISH:   c = '{op: OP_FINISH,   br: BR_NEXT,      target: PC_WAIT};
      PC_EMIT:     c = '{op: OP_EMIT,     br: BR_GOTO,      target: PC_WAIT};
      default:     c = '{op: OP_WAIT,     br: BR_GOTO,      target: PC_WAIT};
    endcase
    return c;
  endfunction

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic logic [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:    v = 26'd2949120;
      5'd1:    v = 26'd1740967;
      5'd2:    v = 26'd919879;
      5'd3:    v = 26'd466945;
      5'd4:    v = 26'd234379;
      5'd5:    v = 26'd117304;
      5'd6:    v = 26'd58666;
      5'd7:    v = 26'd29335;
      5'd8:    v = 26'd14668;
      5'd9:    v = 26'd7334;
      5'd10:   v = 26'd3667;
      5'd11:   v = 26'd1833;
      5'd12:   v = 26'd917;
      5'd13:   v = 26'd458;
      5'd14:   v = 26'd229;
      5'd15:   v = 26'd115;
      5'd16:   v = 26'd57;
      5'd17:   v = 26'd29;
      5'd18:   v = 26'd14;
      5'd19:   v = 26'd7;
      5'd20:   v = 26'd4;
      5'd21:   v = 26'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/wta_in_if.sv */
`timescale 1ns / 1ps

interface wta_in_if;
  logic              valid;
  logic              ready;
  logic              restart;
  logic signed [7:0] x_sample;
  logic signed [7:0] y_sample;

  modport source (output valid, restart, x_sample, y_sample, input ready);
  modport sink   (input valid, restart, x_sample, y_sample, output ready);
endinterface

/* hdl/wta_out_if.sv */
`timescale 1ns / 1ps

interface wta_out_if;
  logic        valid;
  logic        ready;
  logic        angle_valid;
  logic [12:0] tilt_angle;

  modport source (output valid, angle_valid, tilt_angle, input ready);
  modport sink   (input valid, angle_valid, tilt_angle, output ready);
endinterface

/* hdl/wta_seq.sv */
`timescale 1ns / 1ps

module wta_seq (
  input  logic           clk,
  input  logic           rst,
  input  wta_pkg::stat_t stat,
  output wta_pkg::ctl_t  ctl
);
  import wta_pkg::*;

  pc_t  pc;
  pc_t  pc_next;
  logic take;

  assign ctl = ucode(pc);

  always_comb begin
    case (ctl.br)
      BR_NEXT:      take = 1'b0;
      BR_GOTO:      take = 1'b1;
      BR_IDLE:      take = !stat.start;
      BR_SUM_MORE:  take = stat.sum_more;
      BR_ITER_MORE: take = stat.iter_more;
      BR_SPECIAL:   take = stat.special;
      default:      take = 1'b1;
    endcase
    if (stat.hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctl.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* hdl/wta_dp.sv */
`timescale 1ns / 1ps

module wta_dp #(
  parameter int WINDOW = wta_pkg::WINDOW_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  wta_pkg::ctl_t   ctl,
  output wta_pkg::stat_t  stat,
  wta_in_if.sink          samples,
  wta_out_if.source       result
);
  import wta_pkg::*;

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int LC_W   = (IDX_W > STEP_W) ? IDX_W : STEP_W;
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int CW     = SUM_W + PRESHIFT + GUARD_W;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [LC_W-1:0]   SUM_LAST  = LC_W'(WINDOW - 1);
  localparam logic [LC_W-1:0]   ITER_LAST = LC_W'(CORDIC_STEPS - 1);

  // window store: {x, y} per entry
  logic [2*SAMPLE_W-1:0] mem [WINDOW];
  logic [2*SAMPLE_W-1:0] rd_data;

  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  idx;
  logic [FILL_W-1:0] fill;
  logic [LC_W-1:0]   lc;

  logic signed [SUM_W-1:0] acc_x;
  logic signed [SUM_W-1:0] acc_y;
  logic signed [CW-1:0]    cx;
  logic signed [CW-1:0]    cy;
  logic signed [Z_W-1:0]   z;
  logic                    neg;
  logic [ANG_W-1:0]        angle;

  logic             out_valid;
  logic             out_angle_valid;
  logic [ANG_W-1:0] out_tilt;

  logic xfer;
  logic start;
  logic out_free;
  logic emit;

  logic signed [SAMPLE_W-1:0] rd_x;
  logic signed [SAMPLE_W-1:0] rd_y;
  logic [SUM_W-1:0]           abs_x;
  logic [SUM_W-1:0]           abs_y;
  logic signed [CW-1:0]       xs;
  logic signed [CW-1:0]       ys;
  logic signed [Z_W-1:0]      step_angle;
  logic signed [Z_W-1:0]      z_round;
  logic signed [ZR_W-1:0]     zr;
  logic [MAG_W-1:0]           mag;
  logic [ANG_W-1:0]           special_angle;

  assign out_free      = !out_valid || result.ready;
  assign samples.ready = (ctl.op == OP_WAIT) && out_free;
  assign xfer          = samples.valid && samples.ready;
  assign start         = xfer && !samples.restart && (fill == FILL_FULL);
  assign emit          = (ctl.op == OP_EMIT) && out_free;

  assign stat.start     = start;
  assign stat.sum_more  = (lc != SUM_LAST);
  assign stat.iter_more = (lc != ITER_LAST);
  assign stat.special   = (acc_x == '0) || (acc_y == '0);
  assign stat.hold      = (ctl.op == OP_EMIT) && !out_free;

  assign result.valid       = out_valid;
  assign result.angle_valid = out_angle_valid;
  assign result.tilt_angle  = out_tilt;

  assign rd_x       = rd_data[2*SAMPLE_W-1:SAMPLE_W];
  assign rd_y       = rd_data[SAMPLE_W-1:0];
  assign abs_x      = acc_x[SUM_W-1] ? SUM_W'(-acc_x) : SUM_W'(acc_x);
  assign abs_y      = acc_y[SUM_W-1] ? SUM_W'(-acc_y) : SUM_W'(acc_y);
  assign xs         = cx >>> lc;
  assign ys         = cy >>> lc;
  assign step_angle = $signed(atan_entry(lc[STEP_W-1:0]));
  assign z_round    = z + $signed(ROUND_HALF);
  assign zr         = z_round[Z_W-1:ROUND_BITS];

  always_comb begin
    if (zr[ZR_W-1]) begin
      mag = '0;
    end else if (zr > $signed(ZR_W'(QUARTER))) begin
      mag = QUARTER;
    end else begin
      mag = zr[MAG_W-1:0];
    end
  end

  always_comb begin
    if (acc_x != '0) begin
      special_angle = HALF_TURN;
    end else if (acc_y[SUM_W-1]) begin
      special_angle = HALF_TURN - ANG_W'(QUARTER);
    end else if (acc_y != '0) begin
      special_angle = HALF_TURN + ANG_W'(QUARTER);
    end else begin
      special_angle = HALF_TURN;
    end
  end

  // window store, registered read
  always_ff @(posedge clk) begin
    if (xfer && !samples.restart) begin
      mem[slot] <= {samples.x_sample, samples.y_sample};
    end
    rd_data <= mem[idx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (xfer) begin
        if (samples.restart) begin
          fill <= '0;
        end else begin
          slot <= (slot == IDX_LAST) ? '0 : slot + 1'b1;
          if (fill != FILL_FULL) begin
            fill <= fill + 1'b1;
          end
        end
      end
      if ((xfer && !start) || emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    if (xfer && !start) begin
      out_angle_valid <= 1'b0;
      out_tilt        <= '0;
    end else if (emit) begin
      out_angle_valid <= 1'b1;
      out_tilt        <= angle;
    end
    unique case (ctl.op)
      OP_WAIT: begin
        if (start) begin
          acc_x <= '0;
          acc_y <= '0;
          idx   <= '0;
          lc    <= '0;
        end
      end
      OP_PRIME: begin
        idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
      end
      OP_SUM: begin
        acc_x <= acc_x + SUM_W'(rd_x);
        acc_y <= acc_y + SUM_W'(rd_y);
        idx   <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
        lc    <= lc + 1'b1;
      end
      OP_CLASSIFY: begin
        angle <= special_angle;
        cx    <= $signed({{GUARD_W{1'b0}}, abs_x, {PRESHIFT{1'b0}}});
        cy    <= $signed({{GUARD_W{1'b0}}, abs_y, {PRESHIFT{1'b0}}});
        z     <= '0;
        neg   <= acc_x[SUM_W-1] ^ acc_y[SUM_W-1];
        lc    <= '0;
      end
      OP_ITER: begin
        if (!cy[CW-1]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          z  <= z + step_angle;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          z  <= z - step_angle;
        end
        lc <= lc + 1'b1;
      end
      OP_FINISH: begin
        angle <= neg ? HALF_TURN - ANG_W'(mag) : HALF_TURN + ANG_W'(mag);
      end
      OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_in_wait: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |-> (ctl.op == OP_WAIT))
    else $error("sample taken outside the wait step");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("fill count above window depth");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_angle_valid) |->
      (out_tilt >= HALF_TURN - ANG_W'(QUARTER)) && (out_tilt <= HALF_TURN + ANG_W'(QUARTER)))
    else $error("angle out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_angle_valid) |-> (out_tilt == '0))
    else $error("invalid result carries a nonzero angle");

  a_emit_stall: assert property (@(posedge clk) disable iff (rst)
    ((ctl.op == OP_EMIT) && out_valid && !result.ready) |=> (ctl.op == OP_EMIT))
    else $error("emit step left while output stalled");
`endif

endmodule

/* hdl/windowed_tilt_angle_core.sv */
`timescale 1ns / 1ps

// Tilt angle from windowed sums of x and y acceleration.
// samples (sink): restart, x_sample, y_sample. result (source): angle_valid,
// tilt_angle = 180 + atan(sum_y / sum_x) degrees in 1/16 degree (1440..4320).
// Every sample transfer gives exactly one result transfer.
// A restart transfer clears the fill count and returns angle_valid = 0; the
// first WINDOW samples after reset or restart only fill the window and also
// return angle_valid = 0, registered in the cycle after the transfer.
// Once the window is full a microcoded sequencer runs each sample: one store
// prime step, WINDOW accumulate steps (one window entry per cycle through
// the single read port), one classify step, 22 shared CORDIC iterations, one
// rounding step and one output step. The next sample is taken only after
// the output step, once the sequencer is back in its wait step. When sum_x
// or sum_y is zero the CORDIC iterations and the rounding step are skipped.
// Reset clears the sequencer, write slot, fill count and output valid flag;
// the window store is not cleared. If the receiver stalls, the result holds in
// the output register and samples.ready stays low until it has been taken.
module windowed_tilt_angle_core #(
  parameter int WINDOW = wta_pkg::WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst,
  wta_in_if.sink    samples,
  wta_out_if.source result
);
  import wta_pkg::*;

  // control word from the microcode ROM, status back from the datapath
  ctl_t  ctl;
  stat_t stat;

  // step counter and conditional jumps
  wta_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // window store, sums, CORDIC and output register
  wta_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .stat    (stat),
    .samples (samples),
    .result  (result)
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import wta_pkg::*;

  localparam int WIN        = WINDOW_DEF;
  localparam int N_RANDOM   = 1950;
  localparam int MAX_PRINTS = 40;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  localparam longint ATAN_TBL [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  typedef struct {
    bit          angle_valid;
    logic [12:0] tilt_angle;
  } angle_t;

  // Shadow of the window and fill logic, plus the queue of angles still owed
  // by the block. One entry is pushed per sample transfer (restarts too).
  class tilt_angle_scoreboard;
    logic signed [7:0] x_win [WIN];
    logic signed [7:0] y_win [WIN];
    int     slot;
    int     fill;
    angle_t owed_angles [$];
    int     errors;
    int     samples;
    int     restarts;
    int     angles;
    int     zero_x;
    int     zero_y;

    function new();
      for (int i = 0; i < WIN; i++) begin
        x_win[i] = '0;
        y_win[i] = '0;
      end
      slot     = 0;
      fill     = 0;
      errors   = 0;
      samples  = 0;
      restarts = 0;
      angles   = 0;
      zero_x   = 0;
      zero_y   = 0;
    endfunction

    // vectoring CORDIC on |sum_x|, |sum_y|; magnitude in 1/16 degree
    function logic [MAG_W-1:0] arctan_16ths(int ax, int ay);
      longint cx;
      longint cy;
      longint cz;
      longint dx;
      longint dy;
      cx = longint'(ax) <<< PRESHIFT;
      cy = longint'(ay) <<< PRESHIFT;
      cz = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = cx >>> i;
        dy = cy >>> i;
        if (cy >= 0) begin
          cx = cx + dy;
          cy = cy - dx;
          cz = cz + ATAN_TBL[i];
        end else begin
          cx = cx - dy;
          cy = cy + dx;
          cz = cz - ATAN_TBL[i];
        end
      end
      cz = (cz + 2048) >>> ROUND_BITS;
      if (cz < 0) cz = 0;
      if (cz > QUARTER) cz = QUARTER;
      return cz[MAG_W-1:0];
    endfunction

    function void note_sample(bit restart, logic signed [7:0] xs, logic signed [7:0] ys);
      angle_t e;
      int sx;
      int sy;
      logic [MAG_W-1:0] mag;
      e.angle_valid = 1'b0;
      e.tilt_angle  = '0;
      samples++;
      if (restart) begin
        fill = 0;
        restarts++;
      end else begin
        x_win[slot] = xs;
        y_win[slot] = ys;
        slot = (slot + 1) % WIN;
        if (fill < WIN) begin
          fill++;
        end else begin
          sx = 0;
          sy = 0;
          for (int i = 0; i < WIN; i++) begin
            sx += x_win[i];
            sy += y_win[i];
          end
          e.angle_valid = 1'b1;
          if (sx == 0) begin
            zero_x++;
            if (sy > 0) e.tilt_angle = HALF_TURN + QUARTER;
            else if (sy < 0) e.tilt_angle = HALF_TURN - QUARTER;
            else e.tilt_angle = HALF_TURN;
          end else if (sy == 0) begin
            zero_y++;
            e.tilt_angle = HALF_TURN;
          end else begin
            mag = arctan_16ths(sx < 0 ? -sx : sx, sy < 0 ? -sy : sy);
            if ((sx < 0) != (sy < 0)) e.tilt_angle = HALF_TURN - mag;
            else e.tilt_angle = HALF_TURN + mag;
          end
        end
      end
      owed_angles.push_back(e);
    endfunction

    function void check_angle(logic av, logic [12:0] ang);
      angle_t e;
      if (owed_angles.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: unexpected result transfer, expected none, actual valid=%0b angle=%0d",
                   $time, av, ang);
        return;
      end
      e = owed_angles.pop_front();
      if (av !== e.angle_valid) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: angle_valid mismatch, expected %0b, actual %0b",
                   $time, e.angle_valid, av);
      end
      if (ang !== e.tilt_angle) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: tilt_angle mismatch, expected %0d, actual %0d",
                   $time, e.tilt_angle, ang);
      end
      if (e.angle_valid) angles++;
    endfunction

    function int pending();
      return owed_angles.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   send_idle;
  bit   recv_idle;

  wta_in_if  samples_if ();
  wta_out_if result_if ();

  tilt_angle_scoreboard sb = new();

  windowed_tilt_angle_core #(.WINDOW(WIN)) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .result  (result_if)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watch both channels at every rising edge. All drivers use nonblocking
  // assignments, so the values read here are the ones before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (samples_if.valid && samples_if.ready)
        sb.note_sample(samples_if.restart, samples_if.x_sample, samples_if.y_sample);
      if (result_if.valid && result_if.ready)
        sb.check_angle(result_if.angle_valid, result_if.tilt_angle);
    end
  end

  // Offer one item; hold valid across back-to-back transfers and only drop it
  // when a gap is drawn.
  task automatic send_sample(bit restart, logic signed [7:0] xs, logic signed [7:0] ys);
    int gap;
    gap = send_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid    <= 1'b1;
    samples_if.restart  <= restart;
    samples_if.x_sample <= xs;
    samples_if.y_sample <= ys;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  // Stall the sender until every owed angle has come back. Always wait on an
  // edge first so the last transfer is noted before the count is read.
  task automatic drain_angles();
    samples_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Draw one sample value; the modes bias toward extremes and toward the
  // small values that make the window sums land on zero.
  function automatic logic signed [7:0] draw_value(int mode);
    logic signed [7:0] v;
    case (mode)
      0: v = 8'($urandom_range(0, 255));
      1: v = 8'($signed($urandom_range(0, 4)) - 2);
      2: begin
        case ($urandom_range(0, 4))
          0: v = -8'sd128;
          1: v = 8'sd127;
          2: v = 8'sd0;
          3: v = -8'sd1;
          default: v = 8'sd1;
        endcase
      end
      default: v = 8'($signed($urandom_range(0, 40)) - 20);
    endcase
    return v;
  endfunction

  // Receiver: draw a stall before each result, then hold ready until the
  // transfer. Keep ready high across a zero stall.
  initial begin
    int gap;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  // Stimulus
  initial begin
    int sent;
    int burst;
    int len;
    int mode;
    rst                 <= 1'b1;
    samples_if.valid    <= 1'b0;
    samples_if.restart  <= 1'b0;
    samples_if.x_sample <= '0;
    samples_if.y_sample <= '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. One fill sample, then a restart with junk fields.
    send_sample(1'b0, 8'sd127, -8'sd128);
    send_sample(1'b1, -8'sd128, 8'sd127);
    // Refill so the x window sums to zero and y holds only one nonzero entry.
    send_sample(1'b0, 8'sd127, 8'sd10);
    send_sample(1'b0, -8'sd127, 8'sd0);
    send_sample(1'b0, 8'sd100, 8'sd0);
    send_sample(1'b0, -8'sd100, 8'sd0);
    send_sample(1'b0, 8'sd5, 8'sd0);
    send_sample(1'b0, -8'sd5, 8'sd0);
    send_sample(1'b0, 8'sd1, 8'sd0);
    send_sample(1'b0, -8'sd1, 8'sd0);
    // Each of these replaces the oldest entry:
    // zero sum_x with positive, negative and zero sum_y,
    send_sample(1'b0, 8'sd127, 8'sd10);
    send_sample(1'b0, -8'sd127, -8'sd20);
    send_sample(1'b0, 8'sd100, 8'sd10);
    // zero sum_y with nonzero sum_x, then opposite and matching signs.
    send_sample(1'b0, -8'sd90, 8'sd0);
    send_sample(1'b0, -8'sd128, 8'sd127);
    send_sample(1'b0, -8'sd128, -8'sd128);
    send_sample(1'b0, 8'sd127, -8'sd128);
    // Restart after a full window, one fill, restart again mid-fill.
    send_sample(1'b1, 8'sd127, 8'sd127);
    send_sample(1'b0, -8'sd1, -8'sd1);
    send_sample(1'b1, 8'sd0, 8'sd0);
    drain_angles();

    // Random bursts: each picks a value mode and whether either side idles.
    // Restarts are sprinkled in to break the fill sequence now and then.
    sent  = 0;
    burst = 0;
    while (sent < N_RANDOM) begin
      len       = $urandom_range(20, 120);
      mode      = $urandom_range(0, 3);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if (burst % 8 == 3) drain_angles();
      for (int k = 0; k < len && sent < N_RANDOM; k++) begin
        send_sample($urandom_range(0, 49) == 0, draw_value(mode), draw_value(mode));
        sent++;
      end
      burst++;
    end

    // Let the last angles come back, then keep the clock running to catch any
    // stray transfer.
    drain_angles();
    repeat (WIN + 40) @(posedge clk);

    $display("Run covered %0d sample transfers with %0d restarts; %0d angles checked.",
             sb.samples, sb.restarts, sb.angles);
    $display("Of those, %0d had zero sum_x and %0d had zero sum_y alone.",
             sb.zero_x, sb.zero_y);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d angles never arrived, expected 0 outstanding, actual %0d",
                 $time, sb.pending(), sb.pending());
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d angles outstanding", $time, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
